// ----- rtl/wvg_pkg.sv -----
// Wedge vertex generator package: word types, parameter indexes, queue and sequencer types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package wvg_pkg;
	localparam int NUM_PARAMS = 13;
	localparam int IDXW       = 4;
	localparam int VW         = 34;
	localparam int PW         = 36;
	localparam int SQRT_STEPS = 32;
	localparam int NUM_OPS    = 18;

	localparam logic [IDXW-1:0] IDX_XEXT   = 4'd0;
	localparam logic [IDXW-1:0] IDX_YEXT   = 4'd1;
	localparam logic [IDXW-1:0] IDX_ZEXT   = 4'd2;
	localparam logic [IDXW-1:0] IDX_TOPX   = 4'd3;
	localparam logic [IDXW-1:0] IDX_CORNER = 4'd4;
	localparam logic [IDXW-1:0] IDX_XDIR   = 4'd7;
	localparam logic [IDXW-1:0] IDX_XDIR_Y = 4'd8;
	localparam logic [IDXW-1:0] IDX_ZDIR   = 4'd10;
	localparam logic [IDXW-1:0] IDX_ZDIR_Z = 4'd12;

	typedef logic [NUM_PARAMS-1:0][31:0] wedge_t;

	typedef struct packed {
		logic [3:0]         param_index;
		logic signed [31:0] param_value;
		logic               last_param;
	} in_word_t;

	typedef struct packed {
		logic [2:0]         vertex_index;
		logic signed [31:0] vert_x;
		logic signed [31:0] vert_y;
		logic signed [31:0] vert_z;
		logic               bad_extent;
		logic               final_item;
	} out_word_t;

	typedef struct packed {
		logic   valid;
		wedge_t wedge;
	} q_push_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_CHECK,
		B_SQ_MUL,
		B_SQ_ACC,
		B_SQRT,
		B_DIV_INIT,
		B_DIV,
		B_PR_MUL,
		B_PR_ACC,
		B_EMIT
	} back_state_t;
endpackage
`default_nettype wire

// ----- rtl/wedge_vertex_generator_top.sv -----
// Right-angle wedge vertex generator, top level.
// Instantiates wvg_front, wvg_queue and wvg_back; depends on wvg_pkg.
//
//   channel   handshake            word
//   input     start / busy         param  (index, value, last mark)
//   output    strobe (no stall)    result (vertex index, x, y, z, flags)
//
// One parameter word per cycle while busy is low; busy rises only when two
// loaded wedges wait in the queue. The back end takes one wedge at a time
// through the bit-serial square root and divider, then emits 8 vertices on
// consecutive cycles. A bad wedge is checked in B_CHECK after it leaves
// the queue, and its error word is then registered onto the output.
// Reset returns the parameter store to defaults and empties the queue.
`timescale 1ns / 1ps
`default_nettype none
module wedge_vertex_generator_top #(
	parameter int FRAC_BITS = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  wvg_pkg::in_word_t  param,
	output logic               strobe,
	output wvg_pkg::out_word_t result
);
	import wvg_pkg::*;

	q_push_t push;
	q_stat_t q_stat;
	wedge_t  head;
	logic    pop;

	wvg_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.param  (param),
		.q_stat (q_stat),
		.push   (push)
	);

	wvg_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.q_stat (q_stat)
	);

	wvg_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.strobe (strobe),
		.result (result)
	);

	assign busy = q_stat.full;

	a_err_final: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.bad_extent |-> result.final_item && result.vertex_index == 3'd0)
		else $error("error word not final");

	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.final_item |=> strobe &&
		result.vertex_index == $past(result.vertex_index) + 3'd1)
		else $error("vertex burst broken");

	a_final_idx: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.bad_extent && result.final_item |-> result.vertex_index == 3'd7)
		else $error("final vertex index wrong");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");
endmodule
`default_nettype wire

// ----- rtl/wvg_front.sv -----
// Front end: takes parameter words into the store, hands a full wedge to the queue.
// Depends on wvg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wvg_front #(
	parameter int FRAC_BITS = 16
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	input  wvg_pkg::in_word_t param,
	input  wvg_pkg::q_stat_t  q_stat,
	output wvg_pkg::q_push_t  push
);
	import wvg_pkg::*;

	localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

	function automatic wedge_t defaults();
		wedge_t d;
		d = '0;
		d[IDX_XDIR_Y] = ONE;
		d[IDX_ZDIR_Z] = ONE;
		return d;
	endfunction

	wedge_t store_q;
	wedge_t store_nxt;
	logic   accept;

	assign accept = start && !q_stat.full;

	always_comb begin
		store_nxt = store_q;
		if (param.param_index < IDXW'(NUM_PARAMS))
			store_nxt[param.param_index] = param.param_value;
	end

	assign push.valid = accept && param.last_param;
	assign push.wedge = store_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q <= defaults();
		end else if (accept) begin
			store_q <= param.last_param ? defaults() : store_nxt;
		end
	end
endmodule
`default_nettype wire

// ----- rtl/wvg_queue.sv -----
// Two-entry queue of loaded wedges between front and back.
// Depends on wvg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wvg_queue (
	input  wire              clk,
	input  wire              arst_n,
	input  wvg_pkg::q_push_t push,
	input  wire              pop,
	output wvg_pkg::wedge_t  head,
	output wvg_pkg::q_stat_t q_stat
);
	import wvg_pkg::*;

	localparam int QD = 2;
	localparam int AW = 1;

	wedge_t         mem_q [QD];
	logic [AW-1:0]  wr_q;
	logic [AW-1:0]  rd_q;
	logic [AW:0]    cnt_q;

	always_ff @(posedge clk) begin
		if (push.valid)
			mem_q[wr_q] <= push.wedge;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.valid)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push.valid && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push.valid)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	assign head         = mem_q[rd_q];
	assign q_stat.empty = (cnt_q == '0);
	assign q_stat.full  = (cnt_q == (AW+1)'(QD));
endmodule
`default_nettype wire

// ----- rtl/wvg_back.sv -----
// Back end: unitize, cross product, scale and emit eight vertices (or one error word).
// Shared 32x32 multiplier, bit-serial square root and divider. Depends on wvg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wvg_back #(
	parameter int FRAC_BITS = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wvg_pkg::wedge_t    head,
	input  wvg_pkg::q_stat_t   q_stat,
	output logic               pop,
	output logic               strobe,
	output wvg_pkg::out_word_t result
);
	import wvg_pkg::*;

	localparam int DW  = 32 + FRAC_BITS;
	localparam int DCW = $clog2(DW + 1);

	function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
		if (v > PW'(signed'(32'sh7fffffff)))
			return 32'sh7fffffff;
		else if (v < PW'(signed'(32'sh80000000)))
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	back_state_t state_q, state_d;

	wedge_t               pw_q;
	logic                 vsel_q;
	logic [1:0]           cnt_q;
	logic [4:0]           op_q;
	logic [4:0]           it_q;
	logic [DCW-1:0]       dit_q;
	logic [2:0]           vidx_q;
	logic [63:0]          sum_q;
	logic [63:0]          n_q;
	logic [33:0]          rem_q;
	logic [31:0]          root_q;
	logic [DW-1:0]        dvd_q;
	logic [31:0]          drem_q;
	logic                 neg_q;
	logic signed [31:0]   xd_q [3];
	logic signed [31:0]   zd_q [3];
	logic signed [31:0]   yd_q [3];
	logic signed [63:0]   prod_q;
	logic signed [63:0]   acc_q;
	logic signed [VW-1:0] xv_q [3];
	logic signed [VW-1:0] txv_q [3];
	logic signed [VW-1:0] zv_q [3];
	logic signed [VW-1:0] yv_q [3];
	out_word_t            res_q;
	logic                 strobe_q;

	logic [IDXW-1:0]      cidx;
	logic signed [31:0]   comp;
	logic [31:0]          comp_mag;
	logic signed [31:0]   mul_a, mul_b;
	logic signed [63:0]   mul_p;
	logic [35:0]          rem_sh, trial;
	logic [32:0]          drem_sh;
	logic                 qbit;
	logic [DW-1:0]        quo;
	logic signed [31:0]   unit;
	logic                 bad;
	logic                 sq_last, div_last, pr_last;
	logic signed [PW-1:0] vtx [3];

	assign cidx     = vsel_q ? (IDX_ZDIR + IDXW'(cnt_q)) : (IDX_XDIR + IDXW'(cnt_q));
	assign comp     = pw_q[cidx];
	assign comp_mag = comp[31] ? (32'd0 - comp) : comp;
	assign bad      = pw_q[IDX_XEXT][31] || (pw_q[IDX_XEXT] == '0) ||
	                  pw_q[IDX_YEXT][31] || (pw_q[IDX_YEXT] == '0) ||
	                  pw_q[IDX_ZEXT][31] || (pw_q[IDX_ZEXT] == '0);
	assign sq_last  = (it_q == 5'(SQRT_STEPS - 1));
	assign div_last = (dit_q == DCW'(DW - 1));
	assign pr_last  = (op_q == 5'(NUM_OPS - 1));

	assign rem_sh  = {rem_q, n_q[63:62]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign drem_sh = {drem_q, dvd_q[DW-1]};
	assign qbit    = (drem_sh >= {1'b0, root_q});
	assign quo     = {dvd_q[DW-2:0], qbit};
	assign unit    = (root_q == '0) ? 32'sd0 :
	                 (neg_q ? (32'sd0 - signed'(quo[31:0])) : signed'(quo[31:0]));

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == B_SQ_MUL) begin
			mul_a = comp;
			mul_b = comp;
		end else begin
			case (op_q)
				5'd0:  begin mul_a = zd_q[1]; mul_b = xd_q[2]; end
				5'd1:  begin mul_a = zd_q[2]; mul_b = xd_q[1]; end
				5'd2:  begin mul_a = zd_q[2]; mul_b = xd_q[0]; end
				5'd3:  begin mul_a = zd_q[0]; mul_b = xd_q[2]; end
				5'd4:  begin mul_a = zd_q[0]; mul_b = xd_q[1]; end
				5'd5:  begin mul_a = zd_q[1]; mul_b = xd_q[0]; end
				5'd6:  begin mul_a = xd_q[0]; mul_b = pw_q[IDX_XEXT]; end
				5'd7:  begin mul_a = xd_q[1]; mul_b = pw_q[IDX_XEXT]; end
				5'd8:  begin mul_a = xd_q[2]; mul_b = pw_q[IDX_XEXT]; end
				5'd9:  begin mul_a = xd_q[0]; mul_b = pw_q[IDX_TOPX]; end
				5'd10: begin mul_a = xd_q[1]; mul_b = pw_q[IDX_TOPX]; end
				5'd11: begin mul_a = xd_q[2]; mul_b = pw_q[IDX_TOPX]; end
				5'd12: begin mul_a = zd_q[0]; mul_b = pw_q[IDX_ZEXT]; end
				5'd13: begin mul_a = zd_q[1]; mul_b = pw_q[IDX_ZEXT]; end
				5'd14: begin mul_a = zd_q[2]; mul_b = pw_q[IDX_ZEXT]; end
				5'd15: begin mul_a = yd_q[0]; mul_b = pw_q[IDX_YEXT]; end
				5'd16: begin mul_a = yd_q[1]; mul_b = pw_q[IDX_YEXT]; end
				5'd17: begin mul_a = yd_q[2]; mul_b = pw_q[IDX_YEXT]; end
				default: begin mul_a = '0; mul_b = '0; end
			endcase
		end
	end

	assign mul_p = mul_a * mul_b;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic signed [PW-1:0] base;
			base = PW'(signed'(pw_q[IDX_CORNER + IDXW'(i)]));
			case (vidx_q)
				3'd0: vtx[i] = base;
				3'd1: vtx[i] = base + PW'(xv_q[i]);
				3'd2: vtx[i] = base + PW'(xv_q[i]) + PW'(yv_q[i]);
				3'd3: vtx[i] = base + PW'(yv_q[i]);
				3'd4: vtx[i] = base + PW'(zv_q[i]);
				3'd5: vtx[i] = base + PW'(zv_q[i]) + PW'(txv_q[i]);
				3'd6: vtx[i] = base + PW'(zv_q[i]) + PW'(txv_q[i]) + PW'(yv_q[i]);
				default: vtx[i] = base + PW'(zv_q[i]) + PW'(yv_q[i]);
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (!q_stat.empty) begin
					pop     = 1'b1;
					state_d = B_CHECK;
				end
			end
			B_CHECK:    state_d = bad ? B_IDLE : B_SQ_MUL;
			B_SQ_MUL:   state_d = B_SQ_ACC;
			B_SQ_ACC:   state_d = (cnt_q == 2'd2) ? B_SQRT : B_SQ_MUL;
			B_SQRT:     state_d = sq_last ? B_DIV_INIT : B_SQRT;
			B_DIV_INIT: state_d = B_DIV;
			B_DIV: begin
				if (div_last) begin
					if (cnt_q != 2'd2)
						state_d = B_DIV_INIT;
					else
						state_d = vsel_q ? B_PR_MUL : B_SQ_MUL;
				end
			end
			B_PR_MUL:   state_d = B_PR_ACC;
			B_PR_ACC:   state_d = pr_last ? B_EMIT : B_PR_MUL;
			B_EMIT:     state_d = (vidx_q == 3'd7) ? B_IDLE : B_EMIT;
			default:    state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= (state_q == B_EMIT) || (state_q == B_CHECK && bad);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (pop)
					pw_q <= head;
			end
			B_CHECK: begin
				vsel_q <= 1'b0;
				cnt_q  <= '0;
				sum_q  <= '0;
				res_q  <= '{vertex_index: 3'd0, vert_x: '0, vert_y: '0, vert_z: '0,
				           bad_extent: 1'b1, final_item: 1'b1};
			end
			B_SQ_MUL: prod_q <= mul_p;
			B_SQ_ACC: begin
				sum_q <= sum_q + prod_q;
				if (cnt_q == 2'd2) begin
					n_q    <= sum_q + prod_q;
					rem_q  <= '0;
					root_q <= '0;
					it_q   <= '0;
				end else begin
					cnt_q <= cnt_q + 2'd1;
				end
			end
			B_SQRT: begin
				n_q  <= {n_q[61:0], 2'b00};
				it_q <= it_q + 5'd1;
				if (rem_sh >= trial) begin
					rem_q  <= 34'(rem_sh - trial);
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					rem_q  <= rem_sh[33:0];
					root_q <= {root_q[30:0], 1'b0};
				end
				if (sq_last)
					cnt_q <= '0;
			end
			B_DIV_INIT: begin
				neg_q  <= comp[31];
				dvd_q  <= {comp_mag, FRAC_BITS'(0)};
				drem_q <= '0;
				dit_q  <= '0;
			end
			B_DIV: begin
				dvd_q  <= quo;
				drem_q <= qbit ? 32'(drem_sh - {1'b0, root_q}) : drem_sh[31:0];
				dit_q  <= dit_q + 1'b1;
				if (div_last) begin
					if (vsel_q)
						zd_q[cnt_q] <= unit;
					else
						xd_q[cnt_q] <= unit;
					if (cnt_q != 2'd2) begin
						cnt_q <= cnt_q + 2'd1;
					end else begin
						cnt_q  <= '0;
						vsel_q <= 1'b1;
						sum_q  <= '0;
						op_q   <= '0;
					end
				end
			end
			B_PR_MUL: prod_q <= mul_p;
			B_PR_ACC: begin
				op_q   <= op_q + 5'd1;
				vidx_q <= '0;
				case (op_q)
					5'd0, 5'd2, 5'd4: acc_q <= prod_q;
					5'd1:  yd_q[0]  <= 32'((acc_q - prod_q) >>> FRAC_BITS);
					5'd3:  yd_q[1]  <= 32'((acc_q - prod_q) >>> FRAC_BITS);
					5'd5:  yd_q[2]  <= 32'((acc_q - prod_q) >>> FRAC_BITS);
					5'd6:  xv_q[0]  <= VW'(prod_q >>> FRAC_BITS);
					5'd7:  xv_q[1]  <= VW'(prod_q >>> FRAC_BITS);
					5'd8:  xv_q[2]  <= VW'(prod_q >>> FRAC_BITS);
					5'd9:  txv_q[0] <= VW'(prod_q >>> FRAC_BITS);
					5'd10: txv_q[1] <= VW'(prod_q >>> FRAC_BITS);
					5'd11: txv_q[2] <= VW'(prod_q >>> FRAC_BITS);
					5'd12: zv_q[0]  <= VW'(prod_q >>> FRAC_BITS);
					5'd13: zv_q[1]  <= VW'(prod_q >>> FRAC_BITS);
					5'd14: zv_q[2]  <= VW'(prod_q >>> FRAC_BITS);
					5'd15: yv_q[0]  <= VW'(prod_q >>> FRAC_BITS);
					5'd16: yv_q[1]  <= VW'(prod_q >>> FRAC_BITS);
					5'd17: yv_q[2]  <= VW'(prod_q >>> FRAC_BITS);
					default: acc_q <= acc_q;
				endcase
			end
			B_EMIT: begin
				vidx_q <= vidx_q + 3'd1;
				res_q  <= '{vertex_index: vidx_q, vert_x: sat32(vtx[0]),
				           vert_y: sat32(vtx[1]), vert_z: sat32(vtx[2]),
				           bad_extent: 1'b0, final_item: (vidx_q == 3'd7)};
			end
			default: ;
		endcase
	end

	assign strobe = strobe_q;
	assign result = res_q;
endmodule
`default_nettype wire
